@@ hdl/rlstk_pkg.sv @@
// ============================================================================
// rlstk_pkg: shared types and constants of the run-length stack
// Field widths, operation and status codes, and the command and status
// structs that join the controller and the datapath.
// ============================================================================
package rlstk_pkg;

    // field widths
    localparam int MODE_W   = 2;
    localparam int COUNT_W  = 20;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;

    // default run store depth
    localparam int MAX_RUNS_DEF = 1024;

    // capacity after reset
    localparam logic [COUNT_W-1:0] CAPACITY_RST = '1;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TOP  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SIZE = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_HALTED = 2'd3;

    // what the data field of a result carries
    typedef enum logic [1:0] {
        DSEL_NONE = 2'd0,
        DSEL_TOP  = 2'd1,
        DSEL_SIZE = 2'd2
    } data_sel_t;

    // controller to datapath
    typedef struct packed {
        logic                latch;
        logic                push;
        logic                pop_step;
        logic                halt;
        logic                emit;
        logic [STATUS_W-1:0] emit_status;
        data_sel_t           emit_sel;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic              halted;
        logic [MODE_W-1:0] mode;
        logic              push_fail;
        logic              pop_fail;
        logic              top_empty;
        logic              pop_done;
        logic              out_free;
    } dp_sts_t;

endpackage

@@ hdl/rlstk_item_if.sv @@
// ============================================================================
// rlstk_item_if: operation channel
// Valid/ready channel carrying one stack operation per beat.
// ============================================================================
interface rlstk_item_if;

    logic                               valid;
    logic                               ready;
    logic [rlstk_pkg::MODE_W-1:0]       mode;
    logic [rlstk_pkg::COUNT_W-1:0]      count;
    logic [rlstk_pkg::VALUE_W-1:0]      item_value;

    modport source (output valid, output mode, output count, output item_value,
                    input ready);
    modport sink   (input valid, input mode, input count, input item_value,
                    output ready);

endinterface

@@ hdl/rlstk_result_if.sv @@
// ============================================================================
// rlstk_result_if: result channel
// Valid/ready channel carrying one operation result per beat.
// ============================================================================
interface rlstk_result_if;

    logic                               valid;
    logic                               ready;
    logic [rlstk_pkg::STATUS_W-1:0]     status;
    logic                               has_data;
    logic [rlstk_pkg::DATA_W-1:0]       data;

    modport source (output valid, output status, output has_data, output data,
                    input ready);
    modport sink   (input valid, input status, input has_data, input data,
                    output ready);

endinterface

@@ hdl/rlstk_ctrl.sv @@
// ============================================================================
// rlstk_ctrl: operation sequencer
// Accepts one operation, checks it against the datapath status, and steps
// pops through the run store one run at a time.
// ============================================================================
module rlstk_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  rlstk_pkg::dp_sts_t   sts,
    output rlstk_pkg::dp_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_EXEC     = 4'b0010,
        S_POP      = 4'b0100,
        S_POP_WAIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // accept whenever idle, a waiting result holds the next one in execute
    assign item_ready = (state_reg == S_IDLE);

    // next state and datapath commands
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.emit_sel    = rlstk_pkg::DSEL_NONE;
        cmd.emit_status = rlstk_pkg::ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                if (!sts.out_free)
                begin
                    // result register still occupied
                    state_next = S_EXEC;
                end
                else if (sts.halted)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = rlstk_pkg::ST_HALTED;
                end
                else
                begin
                    case (sts.mode)
                        rlstk_pkg::MODE_PUSH:
                        begin
                            cmd.emit = 1'b1;
                            if (sts.push_fail)
                            begin
                                cmd.halt        = 1'b1;
                                cmd.emit_status = rlstk_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.push = 1'b1;
                            end
                        end
                        rlstk_pkg::MODE_POP:
                        begin
                            if (sts.pop_fail)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.halt        = 1'b1;
                                cmd.emit_status = rlstk_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_POP;
                            end
                        end
                        rlstk_pkg::MODE_TOP:
                        begin
                            cmd.emit = 1'b1;
                            if (sts.top_empty)
                            begin
                                cmd.halt        = 1'b1;
                                cmd.emit_status = rlstk_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.emit_sel = rlstk_pkg::DSEL_TOP;
                            end
                        end
                        default:
                        begin
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = rlstk_pkg::DSEL_SIZE;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                if (sts.pop_done)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.pop_step = 1'b1;
                    state_next   = S_POP_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                // new top run count is being read
                state_next = S_POP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    // an accepted operation is always executed next
    a_latch_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |=> (state_reg == S_EXEC))
        else $error("accepted beat not executed");

    // a pop step is always followed by the refetch cycle
    a_step_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_step |=> (state_reg == S_POP_WAIT))
        else $error("pop step without refetch");

    // nothing is accepted while an operation is in flight
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !item_ready)
        else $error("ready while busy");
`endif

endmodule

@@ hdl/rlstk_dp.sv @@
// ============================================================================
// rlstk_dp: run-length stack datapath
// Run store memories, depth and total counters, capacity register, sticky
// error flag and the result register.
// ============================================================================
module rlstk_dp #(
    parameter int MAX_RUNS = rlstk_pkg::MAX_RUNS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // operation payload
    input  logic [rlstk_pkg::MODE_W-1:0]      mode,
    input  logic [rlstk_pkg::COUNT_W-1:0]     count,
    input  logic [rlstk_pkg::VALUE_W-1:0]     item_value,
    // configuration
    input  logic                              cfg_we,
    input  logic [rlstk_pkg::COUNT_W-1:0]     cfg_wdata,
    // result channel
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [rlstk_pkg::STATUS_W-1:0]    res_status,
    output logic                              res_has_data,
    output logic [rlstk_pkg::DATA_W-1:0]      res_data,
    // controller link
    input  rlstk_pkg::dp_cmd_t                cmd,
    output rlstk_pkg::dp_sts_t                sts
);

    localparam int AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int DW = $clog2(MAX_RUNS + 1);
    localparam int CW = rlstk_pkg::COUNT_W;
    localparam int VW = rlstk_pkg::VALUE_W;

    // run store
    logic [VW-1:0] val_mem [0:MAX_RUNS-1];
    logic [CW-1:0] cnt_mem [0:MAX_RUNS-1];

    logic [rlstk_pkg::MODE_W-1:0] mode_reg;
    logic [CW-1:0]                left_reg;
    logic [VW-1:0]                val_reg;
    logic [DW-1:0]                depth_reg;
    logic [CW-1:0]                total_reg;
    logic                         halted_reg;
    logic [CW-1:0]                cap_reg;
    logic [VW-1:0]                rd_val_reg;
    logic [CW-1:0]                rd_cnt_reg;

    logic                         out_valid_reg;
    logic [rlstk_pkg::STATUS_W-1:0] out_status_reg;
    logic                         out_has_reg;
    logic [rlstk_pkg::DATA_W-1:0] out_data_reg;

    logic [DW-1:0] depth_m1;
    logic [AW-1:0] top_addr;
    logic [AW-1:0] push_addr;
    logic [CW:0]   push_sum;
    logic [CW-1:0] take;
    logic          run_gone;

    // top run address, parked at zero on an empty store
    assign depth_m1  = depth_reg - DW'(1);
    assign top_addr  = (depth_reg == '0) ? '0 : depth_m1[AW-1:0];
    assign push_addr = depth_reg[AW-1:0];

    // push limit and pop step amounts
    assign push_sum = {1'b0, total_reg} + {1'b0, left_reg};
    assign take     = (rd_cnt_reg < left_reg) ? rd_cnt_reg : left_reg;
    assign run_gone = (rd_cnt_reg <= left_reg);

    // status to controller
    always_comb
    begin
        sts.halted    = halted_reg;
        sts.mode      = mode_reg;
        sts.push_fail = (push_sum > {1'b0, cap_reg}) || (depth_reg == DW'(MAX_RUNS));
        sts.pop_fail  = (left_reg > total_reg);
        sts.top_empty = (depth_reg == '0);
        sts.pop_done  = (left_reg == '0) || (depth_reg == '0);
        sts.out_free  = !out_valid_reg || res_ready;
    end

    // value memory, read at the top every cycle
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            val_mem[push_addr] <= val_reg;
        end
        rd_val_reg <= val_mem[top_addr];
    end

    // count memory, read at the top every cycle
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            cnt_mem[push_addr] <= left_reg;
        end
        else if (cmd.pop_step && !run_gone)
        begin
            cnt_mem[top_addr] <= rd_cnt_reg - take;
        end
        rd_cnt_reg <= cnt_mem[top_addr];
    end

    // operation payload and remaining pop count
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg <= mode;
            left_reg <= count;
            val_reg  <= item_value;
        end
        else if (cmd.pop_step)
        begin
            left_reg <= left_reg - take;
        end
    end

    // stack counters, capacity and sticky error
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= '0;
            total_reg  <= '0;
            halted_reg <= 1'b0;
            cap_reg    <= rlstk_pkg::CAPACITY_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (cmd.halt)
            begin
                halted_reg <= 1'b1;
            end
            if (cmd.push)
            begin
                depth_reg <= depth_reg + DW'(1);
                total_reg <= push_sum[CW-1:0];
            end
            else if (cmd.pop_step)
            begin
                total_reg <= total_reg - take;
                if (run_gone)
                begin
                    depth_reg <= depth_m1;
                end
            end
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg <= cmd.emit_status;
            case (cmd.emit_sel)
                rlstk_pkg::DSEL_TOP:
                begin
                    out_has_reg  <= 1'b1;
                    out_data_reg <= rd_val_reg;
                end
                rlstk_pkg::DSEL_SIZE:
                begin
                    out_has_reg  <= 1'b1;
                    out_data_reg <= rlstk_pkg::DATA_W'(total_reg);
                end
                default:
                begin
                    out_has_reg  <= 1'b0;
                    out_data_reg <= '0;
                end
            endcase
        end
    end

    assign res_valid    = out_valid_reg;
    assign res_status   = out_status_reg;
    assign res_has_data = out_has_reg;
    assign res_data     = out_data_reg;

`ifndef SYNTHESIS
    // run count never passes the store depth
    a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(MAX_RUNS))
        else $error("run depth overflow");

    // an empty store holds no items
    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        (depth_reg == '0) |-> (total_reg == '0))
        else $error("items counted with no runs");

    // the error flag only clears on reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared");

    // a result never overwrites one still waiting
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || res_ready))
        else $error("result register overrun");

    // pop steps only with a run on the store
    a_step_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_step |-> (depth_reg != '0))
        else $error("pop step on empty store");
`endif

endmodule

@@ hdl/run_length_stack_with_capacity_top.sv @@
// ============================================================================
// run_length_stack_with_capacity_top: run-length stack under item capacity
// Push, pop, top and size operations on a stack of value/count runs, one
// result beat per operation beat, with a sticky error state.
// ============================================================================
// One operation is executed at a time. Push, top and size go from acceptance
// to the result register through accept, then execute, and the next beat is
// not accepted until execute is done. A pop goes through accept, execute,
// then for each run it touches a step that updates the count memory and a
// refetch of the new top run count, and a last check that finds the count
// used up; empty runs passed on the way count as runs.
// The result register lets a new beat be accepted while the previous result
// waits; that beat then holds in execute until the register frees, so a
// stalled result adds its wait to the next operation.
// After any full or empty error every later beat returns status halted until
// reset. The run store memories need no clearing after reset.
module run_length_stack_with_capacity_top #(
    parameter int MAX_RUNS = rlstk_pkg::MAX_RUNS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rlstk_item_if.sink                      item_ch,
    rlstk_result_if.source                  result_ch,
    input  logic                            cfg_we,
    input  logic [rlstk_pkg::COUNT_W-1:0]   cfg_wdata
);

    rlstk_pkg::dp_cmd_t cmd;
    rlstk_pkg::dp_sts_t sts;

    // sequencer
    rlstk_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_ch.valid),
        .item_ready (item_ch.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // run store and counters
    rlstk_dp #(
        .MAX_RUNS (MAX_RUNS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (item_ch.mode),
        .count        (item_ch.count),
        .item_value   (item_ch.item_value),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .res_valid    (result_ch.valid),
        .res_ready    (result_ch.ready),
        .res_status   (result_ch.status),
        .res_has_data (result_ch.has_data),
        .res_data     (result_ch.data),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule
